// ===== design/text_column_limiter_top_defines.svh =====
// ---------------------------------------------------------------------------
// Text column limiter assertion macros
// Shared concurrent assertion forms for the text column limiter.
// ---------------------------------------------------------------------------
`ifndef TEXT_COLUMN_LIMITER_TOP_DEFINES_SVH
`define TEXT_COLUMN_LIMITER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define TCL_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcl assertion failed");

// Next-cycle implication, disabled during reset
`define TCL_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcl assertion failed");

`endif

// ===== design/tcl_pkg.sv =====
// ---------------------------------------------------------------------------
// Text column limiter package
// Character codes, wrap modes and the record passed between the stages.
// ---------------------------------------------------------------------------
package tcl_pkg;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] LIMIT_RESET = 8'd80;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_WORD   = 2'd1,
      MODE_SKIP   = 2'd2
   } wrap_mode_type;

   // Results caused by one input byte: count is 0, 1 or 2. With two
   // results the first is an inserted newline and the second is char_out.
   typedef struct packed {
      logic [1:0] count;
      logic [7:0] char_out;
   } result_type;

   typedef struct packed {
      logic [7:0]    column;
      wrap_mode_type mode;
   } core_status_type;

endpackage

// ===== design/tcl_core.sv =====
// ---------------------------------------------------------------------------
// Text column limiter wrap core
// Column/mode state and the per-byte wrap decision.
// ---------------------------------------------------------------------------
module tcl_core import tcl_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            take,
   input  logic [7:0]      char_in,
   input  logic            end_of_text,
   input  logic [7:0]      max_columns,
   output result_type      result,
   output core_status_type status
);

   logic [7:0]    column_ff, column_in;
   wrap_mode_type mode_ff, mode_in;
   logic [7:0]    limit;
   logic          is_nl, is_blank, finish_word;

   assign limit    = (max_columns == 8'd0) ? 8'd1 : max_columns;
   assign is_nl    = (char_in == CHAR_NL);
   assign is_blank = (char_in == CHAR_SPACE) || (char_in == CHAR_TAB);

   always_comb begin
      column_in       = column_ff;
      mode_in         = mode_ff;
      result.count    = 2'd0;
      result.char_out = char_in;
      finish_word     = 1'b0;

      unique case (mode_ff)
         MODE_WORD: begin
            finish_word = 1'b1;
         end
         MODE_SKIP: begin
            if (!is_blank) begin
               // break the line, then copy the byte from column zero
               result.count = 2'd2;
               column_in    = is_nl ? 8'd0 : 8'd1;
               mode_in      = MODE_NORMAL;
            end
         end
         default: begin
            mode_in = MODE_NORMAL;
            if (column_ff >= limit) begin
               finish_word = 1'b1;
            end else begin
               result.count = 2'd1;
               column_in    = is_nl ? 8'd0 : column_ff + 8'd1;
            end
         end
      endcase

      if (finish_word) begin
         if (is_nl) begin
            result.count = 2'd2;
            column_in    = 8'd0;
            mode_in      = MODE_NORMAL;
         end else if (is_blank) begin
            mode_in = MODE_SKIP;
         end else begin
            result.count = 2'd1;
            mode_in      = MODE_WORD;
         end
      end

      if (end_of_text) begin
         column_in = 8'd0;
         mode_in   = MODE_NORMAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= 8'd0;
         mode_ff   <= MODE_NORMAL;
      end else if (take) begin
         column_ff <= column_in;
         mode_ff   <= mode_in;
      end
   end

   assign status.column = column_ff;
   assign status.mode   = mode_ff;

endmodule

// ===== design/tcl_out.sv =====
// ---------------------------------------------------------------------------
// Text column limiter result buffer
// Holds up to two results of one byte and hands them out in order.
// ---------------------------------------------------------------------------
module tcl_out import tcl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   output logic       can_load,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast
);

   logic [1:0] count_ff, count_in;
   logic [7:0] head_ff, head_in;
   logic [7:0] tail_ff, tail_in;
   logic       drain;

   assign drain    = rsp_tvalid && rsp_tready;
   assign can_load = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_tready);

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (drain) begin
         // advance to the second result
         count_in = count_ff - 2'd1;
         head_in  = tail_ff;
      end
      if (load) begin
         count_in = result.count;
         head_in  = (result.count == 2'd2) ? CHAR_NL : result.char_out;
         tail_in  = result.char_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = head_ff;
   assign rsp_tlast  = (count_ff == 2'd1);

endmodule

// ===== design/text_column_limiter_top.sv =====
// ---------------------------------------------------------------------------
// Text column limiter top level
// Greedy word wrap of a byte stream at a programmable column limit.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : input stream, one text byte per transfer (tdata = char_in),
//            tlast = end_of_text marks the final byte of a text.
//   rsp_*  : result stream, one emitted byte per transfer
//            (tdata = char_out), tlast = last result caused by one input.
//   csr_*  : column limit port; user writes only when block idles; unenforced
// Output timing: the first result of a taken byte shows on rsp_ in the
//   next cycle (one register stage in the result buffer).
// Throughput: one byte per cycle while each byte yields at most one result
//   and rsp_tready is high. A byte that yields two results (inserted newline
//   plus the byte) holds req_tready low while both fill the two-entry buffer.
// Reset: column and mode return to column zero / normal copying, the limit
//   returns to 80 and the result buffer empties.
// Stall: when rsp_tready is low, results hold in the buffer. req_tready is
//   high only while the buffer is empty or its last result leaves in the
//   same cycle, so both results of the next byte always fit; nothing is
//   dropped.
// ---------------------------------------------------------------------------
`include "text_column_limiter_top_defines.svh"

module text_column_limiter_top import tcl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   // input stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   input  logic       req_tlast,   // end_of_text
   // result stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] char_out
   output logic       rsp_tlast,   // last_of_run
   // column limit register
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data  // [7:0] max_columns
);

   logic [7:0]      max_columns_ff;
   logic            req_take;
   logic            can_load;
   result_type      core_result;
   core_status_type core_status;

   // Hold the limit; zero is treated as one inside the core.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_columns_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         max_columns_ff <= csr_wr_data;
      end
   end

   // A byte is taken only when the result buffer can absorb its results.
   assign req_tready = can_load;
   assign req_take   = req_tvalid && req_tready;

   tcl_core u_core (
      .clock       (clock),
      .reset       (reset),
      .take        (req_take),
      .char_in     (req_tdata),
      .end_of_text (req_tlast),
      .max_columns (max_columns_ff),
      .result      (core_result),
      .status      (core_status)
   );

   tcl_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (req_take),
      .result     (core_result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // End of text returns the wrap state to its reset values.
   `TCL_ASSERT_NXT(a_eot_clears, clock, reset, req_take && req_tlast,
      core_status.column == 8'd0 && core_status.mode == MODE_NORMAL)

   // Wrapping only starts at a column at or above a limit of at least one.
   `TCL_ASSERT_IMP(a_wrap_col_nonzero, clock, reset,
      core_status.mode == MODE_WORD || core_status.mode == MODE_SKIP,
      core_status.column != 8'd0)

   // A byte with two results presents the inserted newline first.
   `TCL_ASSERT_NXT(a_break_first, clock, reset, req_take && core_result.count == 2'd2,
      rsp_tvalid && rsp_tdata == CHAR_NL && !rsp_tlast)

endmodule

// ===== test/text_wrap_checker.sv =====
// ---------------------------------------------------------------------------
// Text column limiter checker
// Watches the byte, result and limit ports, predicts the wrapped stream and
// compares every result transfer against the oldest predicted byte.
// ---------------------------------------------------------------------------
module text_wrap_checker import tcl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   input  logic       req_tlast,   // end_of_text
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [7:0] char_out
   input  logic       rsp_tlast,   // last_of_run
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data, // [7:0] max_columns
   output int         fail_count,
   output int         pending_count
);

   localparam int RING_DEPTH = 64;

   typedef struct {
      logic [7:0] char_out;
      logic       last_of_run;
   } wrapped_byte_type;

   // predicted bytes, oldest at rd_total
   wrapped_byte_type expected_bytes[RING_DEPTH];
   int            wr_total = 0;
   int            rd_total = 0;
   logic [7:0]    column_limit;
   logic [7:0]    column;
   wrap_mode_type mode;
   int            failures = 0;

   function automatic logic is_blank(logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB;
   endfunction

   function automatic logic [7:0] next_column(logic [7:0] col, logic [7:0] c);
      return (c == CHAR_NL) ? 8'd0 : col + 8'd1;
   endfunction

   // Greedy wrap of one input byte; queues the bytes it emits.
   task automatic wrap_byte(input logic [7:0] c, input logic eot);
      logic [7:0] lim;
      logic [7:0] run[2];
      int         run_len;
      int         slot;
      lim = (column_limit == 8'd0) ? 8'd1 : column_limit;
      run_len = 0;
      if (mode != MODE_WORD && mode != MODE_SKIP) begin
         mode = MODE_NORMAL;
         if (column >= lim) begin
            mode = MODE_WORD;
         end else begin
            run[run_len] = c;
            run_len++;
            column = next_column(column, c);
         end
      end
      if (mode == MODE_WORD) begin
         if (c == CHAR_NL) begin
            run[0] = CHAR_NL;
            run[1] = c;
            run_len = 2;
            column = 8'd0;
            mode = MODE_NORMAL;
         end else if (is_blank(c)) begin
            mode = MODE_SKIP;
         end else begin
            run[0] = c;
            run_len = 1;
         end
      end else if (mode == MODE_SKIP) begin
         if (!is_blank(c)) begin
            run[0] = CHAR_NL;
            run[1] = c;
            run_len = 2;
            column = next_column(8'd0, c);
            mode = MODE_NORMAL;
         end
      end
      for (int i = 0; i < run_len; i++) begin
         slot = wr_total % RING_DEPTH;
         expected_bytes[slot].char_out    = run[i];
         expected_bytes[slot].last_of_run = (i == run_len - 1);
         wr_total++;
      end
      if (eot) begin
         column = 8'd0;
         mode = MODE_NORMAL;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         wr_total = 0;
         rd_total = 0;
         column_limit = LIMIT_RESET;
         column = 8'd0;
         mode = MODE_NORMAL;
      end else begin
         if (csr_wr_en) begin
            column_limit = csr_wr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (wr_total == rd_total) begin
               $error("result transfer with nothing expected: char_out %02h", rsp_tdata);
               failures++;
            end else begin
               if (rsp_tdata !== expected_bytes[rd_total % RING_DEPTH].char_out) begin
                  $error("char_out: expected %02h, got %02h",
                         expected_bytes[rd_total % RING_DEPTH].char_out, rsp_tdata);
                  failures++;
               end
               if (rsp_tlast !== expected_bytes[rd_total % RING_DEPTH].last_of_run) begin
                  $error("last_of_run: expected %0b, got %0b",
                         expected_bytes[rd_total % RING_DEPTH].last_of_run, rsp_tlast);
                  failures++;
               end
               rd_total++;
            end
         end
         if (req_tvalid && req_tready) begin
            wrap_byte(req_tdata, req_tlast);
         end
      end
      fail_count <= failures;
      pending_count <= wr_total - rd_total;
   end

endmodule

// ===== test/tb_top.sv =====
// ---------------------------------------------------------------------------
// Text column limiter testbench
// Drives text bytes through the limiter under several column limits and
// handshake pressure; the checker predicts and compares the wrapped output.
// ---------------------------------------------------------------------------
module tb_top import tcl_pkg::*;;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;
   int         fail_count;
   int         pending_count;

   // idle odds in percent, changed between phases
   int         send_idle_pct = 31;
   int         recv_idle_pct = 70;

   text_column_limiter_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   text_wrap_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver back-pressure: redraw ready every cycle.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Present one byte and hold it until the transfer happens. Idle cycles
   // go in front of the byte, so valid never drops and rises in one step.
   task automatic send_byte(input logic [7:0] c, input logic eot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= eot;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drop valid, wait for every predicted byte to come out, then let a byte
   // that produced nothing clear the pipeline.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Single-cycle write of the column limit; only called while idle.
   task automatic write_limit(input logic [7:0] limit);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly word bytes, with spaces, tabs and newlines mixed in; word bytes
   // span the full byte range so every data bit toggles.
   function automatic logic [7:0] pick_char(int nl_pct);
      int r;
      r = $urandom_range(99);
      if (r < 18) return CHAR_SPACE;
      if (r < 26) return CHAR_TAB;
      if (r < 26 + nl_pct) return CHAR_NL;
      return 8'($urandom_range(255));
   endfunction

   // One random phase: new limit, then a stream of texts.
   task automatic run_phase(input logic [7:0] limit, input int items,
                            input int nl_pct, input int eot_pct);
      write_limit(limit);
      for (int i = 0; i < items; i++) begin
         send_byte(pick_char(nl_pct), $urandom_range(99) < eot_pct);
      end
      settle();
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;
      req_tlast   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = 8'h00;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: default limit, start a line with the byte extremes.
      send_byte("a", 1'b0);
      send_byte("b", 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      settle();

      // Lower the limit below the current column: the wrap must start at
      // the very next byte.
      write_limit(8'd1);
      send_byte("x", 1'b0);          // finish the word
      send_byte(CHAR_SPACE, 1'b0);   // drop trailing blanks
      send_byte(CHAR_TAB, 1'b0);
      send_byte("y", 1'b0);          // inserted newline, then the byte
      send_byte(CHAR_NL, 1'b0);      // newline ending a word: two newlines
      send_byte("p", 1'b0);
      send_byte("q", 1'b0);
      send_byte(CHAR_SPACE, 1'b0);
      send_byte(CHAR_NL, 1'b0);      // newline while skipping blanks
      send_byte("r", 1'b1);
      // text ends while skipping blanks: no newline is inserted
      send_byte("s", 1'b0);
      send_byte("t", 1'b0);
      send_byte(CHAR_SPACE, 1'b1);
      send_byte("u", 1'b0);
      settle();

      // Widest limit; a plain newline clears the column.
      write_limit(8'd255);
      send_byte("v", 1'b0);
      send_byte(CHAR_NL, 1'b0);
      send_byte("w", 1'b1);
      settle();

      // Random: sender quiet, receiver stalling heavily. The first phase has
      // long unbroken lines so the widest limit is actually reached.
      run_phase(8'd255, 300, 0, 0);
      run_phase(8'd1, 110, 4, 3);

      // Sender idling heavily, receiver mostly ready.
      send_idle_pct = 70;
      recv_idle_pct = 31;
      run_phase(8'($urandom_range(2, 8)), 110, 4, 3);
      run_phase(8'($urandom_range(3, 20)), 110, 5, 2);

      // Full rate on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(8'd40, 110, 2, 1);
      run_phase(8'($urandom_range(1, 255)), 110, 3, 2);

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Hard stop in case the stream hangs.
   initial begin
      #5000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
